@@ design/quoted_string_unescape_parser_macros.svh @@
// Assertion macros used by the checker file.
`ifndef QUOTED_STRING_UNESCAPE_PARSER_MACROS_SVH
`define QUOTED_STRING_UNESCAPE_PARSER_MACROS_SVH

// Checked only outside reset.
`define QSU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define QSU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/qsu_pkg.sv @@
package qsu_pkg;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_FAIL = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic       end_of_input;
      logic [7:0] byte_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last_result;
   } rsp_payload_type;

   localparam logic [7:0] QUOTE_CHAR     = 8'h22;
   localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
   localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;
   localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;
   localparam logic [8:0] BYTE_MAX_VALUE = 9'd255;

endpackage

@@ design/quoted_string_unescape_parser.sv @@
// A result beat is registered and visible on rsp the cycle after its req beat is accepted.
// Throughput: one req beat per cycle while rsp_ready is high; a beat that yields two
// results (a digit run ended by any byte but a backslash, or by end of input) holds
// req_ready low until the first of them has left. A new beat is taken when the result
// buffer is empty or its last entry leaves in the same cycle.
// Synchronous active-high reset: parser idle, digit run cleared, result buffer empty,
// skip_leading_space set to 1.
module quoted_string_unescape_parser import qsu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_STR  = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX  = 3'd3,
      PH_OCT  = 3'd4
   } phase_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type res;
      phase_type       next_phase;
   } str_out_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction

   // Plain handling of a byte inside the string.
   function automatic str_out_type str_step(input logic [7:0] c, input logic eoi);
      str_out_type so;
      so.emit = 1'b0;
      so.res.out_byte = 8'd0;
      so.res.kind = KIND_DATA;
      so.res.last_result = 1'b1;
      so.next_phase = PH_STR;
      priority if (eoi) begin
         so.emit = 1'b1;
         so.res.kind = KIND_ERR;
         so.next_phase = PH_IDLE;
      end else if (c == QUOTE_CHAR) begin
         so.emit = 1'b1;
         so.res.kind = KIND_DONE;
         so.next_phase = PH_IDLE;
      end else if (c == BACKSLASH_CHAR) begin
         so.next_phase = PH_ESC;
      end else begin
         so.emit = 1'b1;
         so.res.out_byte = c;
      end
      return so;
   endfunction

   phase_type       phase_ff, phase_in;
   logic [8:0]      esc_val_ff, esc_val_in;
   logic [1:0]      digit_cnt_ff, digit_cnt_in;
   logic            skip_ff;

   rsp_payload_type head_ff, tail_ff;
   logic [1:0]      buf_cnt_ff;

   logic [7:0]      c;
   logic            eoi;
   str_out_type     str_res;
   logic            hex_ok, oct_ok;
   logic [3:0]      hex_dig;
   logic [8:0]      hex_val, oct_val;
   logic [1:0]      cnt_inc;
   logic [1:0]      n_res;
   rsp_payload_type res0, res1;
   logic            accept, pop;

   assign c   = req_payload.byte_in;
   assign eoi = req_payload.end_of_input;

   always_comb begin
      hex_ok  = 1'b1;
      hex_dig = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_dig = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         hex_dig = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
      hex_ok = hex_ok && !eoi;
   end

   assign oct_ok  = !eoi && (c >= 8'h30) && (c <= 8'h37);
   assign hex_val = {esc_val_ff[4:0], hex_dig};
   assign oct_val = {esc_val_ff[5:0], c[2:0]};
   assign cnt_inc = digit_cnt_ff + 2'd1;
   assign str_res = str_step(c, eoi);

   always_comb begin
      phase_in     = phase_ff;
      esc_val_in   = esc_val_ff;
      digit_cnt_in = digit_cnt_ff;
      n_res        = 2'd0;
      res0         = '{out_byte: 8'd0, kind: KIND_DATA, last_result: 1'b1};
      res1         = str_res.res;
      unique case (phase_ff)
         PH_STR: begin
            phase_in = str_res.next_phase;
            res0     = str_res.res;
            n_res    = {1'b0, str_res.emit};
         end
         PH_ESC: begin
            phase_in = PH_STR;
            n_res    = 2'd1;
            if (eoi) begin
               res0.kind = KIND_ERR;
               phase_in  = PH_IDLE;
            end else begin
               unique case (c)
                  8'h6E: res0.out_byte = 8'h0A;
                  8'h74: res0.out_byte = 8'h09;
                  8'h66: res0.out_byte = 8'h0C;
                  8'h72: res0.out_byte = 8'h0D;
                  8'h76: res0.out_byte = 8'h0B;
                  8'h78: begin
                     n_res        = 2'd0;
                     esc_val_in   = 9'd0;
                     digit_cnt_in = 2'd0;
                     phase_in     = PH_HEX;
                  end
                  8'h30: begin
                     n_res        = 2'd0;
                     esc_val_in   = 9'd0;
                     digit_cnt_in = 2'd0;
                     phase_in     = PH_OCT;
                  end
                  default: begin
                     if (is_punct(c)) begin
                        res0.out_byte = c;
                     end else begin
                        res0.kind = KIND_ERR;
                        phase_in  = PH_IDLE;
                     end
                  end
               endcase
            end
         end
         PH_HEX: begin
            if (hex_ok) begin
               esc_val_in   = hex_val;
               digit_cnt_in = cnt_inc;
               if (cnt_inc >= HEX_DIGITS_MAX) begin
                  n_res         = 2'd1;
                  res0.out_byte = hex_val[7:0];
                  esc_val_in    = 9'd0;
                  digit_cnt_in  = 2'd0;
                  phase_in      = PH_STR;
               end
            end else begin
               esc_val_in   = 9'd0;
               digit_cnt_in = 2'd0;
               if (digit_cnt_ff == 2'd0) begin
                  n_res     = 2'd1;
                  res0.kind = KIND_ERR;
                  phase_in  = PH_IDLE;
               end else begin
                  // run ended: emit its value, then handle this byte in the string
                  res0.out_byte = esc_val_ff[7:0];
                  n_res         = str_res.emit ? 2'd2 : 2'd1;
                  phase_in      = str_res.next_phase;
               end
            end
         end
         PH_OCT: begin
            if (oct_ok) begin
               esc_val_in   = oct_val;
               digit_cnt_in = cnt_inc;
               if (cnt_inc >= OCT_DIGITS_MAX) begin
                  n_res        = 2'd1;
                  esc_val_in   = 9'd0;
                  digit_cnt_in = 2'd0;
                  if (oct_val > BYTE_MAX_VALUE) begin
                     res0.kind = KIND_ERR;
                     phase_in  = PH_IDLE;
                  end else begin
                     res0.out_byte = oct_val[7:0];
                     phase_in      = PH_STR;
                  end
               end
            end else begin
               esc_val_in    = 9'd0;
               digit_cnt_in  = 2'd0;
               res0.out_byte = esc_val_ff[7:0];
               n_res         = str_res.emit ? 2'd2 : 2'd1;
               phase_in      = str_res.next_phase;
            end
         end
         default: begin
            // idle, and the unused phase codes
            phase_in = PH_IDLE;
            if (eoi) begin
               n_res     = 2'd1;
               res0.kind = KIND_FAIL;
            end else if (c == QUOTE_CHAR) begin
               esc_val_in   = 9'd0;
               digit_cnt_in = 2'd0;
               phase_in     = PH_STR;
            end else if (!(skip_ff && is_space(c))) begin
               n_res     = 2'd1;
               res0.kind = KIND_FAIL;
            end
         end
      endcase
      res0.last_result = (n_res == 2'd1);
      res1.last_result = 1'b1;
   end

   // Two-entry result buffer; a new beat is taken only when it will be empty.
   assign rsp_valid   = (buf_cnt_ff != 2'd0);
   assign rsp_payload = head_ff;
   assign pop         = rsp_valid && rsp_ready;
   assign req_ready   = (buf_cnt_ff == 2'd0) || (buf_cnt_ff == 2'd1 && rsp_ready);
   assign accept      = req_valid && req_ready;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         esc_val_ff   <= 9'd0;
         digit_cnt_ff <= 2'd0;
         skip_ff      <= 1'b1;
         buf_cnt_ff   <= 2'd0;
      end else begin
         if (csr_valid) begin
            skip_ff <= csr_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            esc_val_ff   <= esc_val_in;
            digit_cnt_ff <= digit_cnt_in;
            head_ff      <= res0;
            tail_ff      <= res1;
            buf_cnt_ff   <= n_res;
         end else if (pop) begin
            head_ff    <= tail_ff;
            buf_cnt_ff <= buf_cnt_ff - 2'd1;
         end
      end
   end

endmodule

@@ design/qsu_checker.sv @@
`include "quoted_string_unescape_parser_macros.svh"

module qsu_checker import qsu_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   `QSU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "rsp beat changed while stalled")
   `QSU_ASSERT(a_ctrl_byte_zero, rsp_valid && rsp_payload.kind != KIND_DATA |-> rsp_payload.out_byte == 8'd0, "nonzero byte on an ending result")
   `QSU_ASSERT(a_end_is_last, rsp_valid && rsp_payload.kind != KIND_DATA |-> rsp_payload.last_result, "ending result not marked last")
   `QSU_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind quoted_string_unescape_parser qsu_checker u_qsu_checker (.*);

@@ tb/quoted_string_unescape_parser_test.sv @@
module quoted_string_unescape_parser_test;
   import qsu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS_PER_MODE = 300;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_STR  = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX  = 3'd3,
      PH_OCT  = 3'd4
   } parse_phase_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic            csr_data = 1'b0;

   // predictor state
   parse_phase_type phase = PH_IDLE;
   logic [8:0]      run_value = '0;
   logic [1:0]      run_digits = '0;
   bit              skip_space = 1'b1;

   rsp_payload_type decoded_q[$];
   int              mismatches = 0;
   int              items_sent = 0;
   int              send_gap_pct = 0;
   int              recv_stall_pct = 0;
   int              hold_cycles = 0;

   quoted_string_unescape_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit is_ws(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_punct(logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction

   function automatic int hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
   endfunction

   function automatic req_payload_type plain(logic [7:0] b);
      return req_payload_type'{end_of_input: 1'b0, byte_in: b};
   endfunction

   function automatic req_payload_type end_mark();
      return req_payload_type'{end_of_input: 1'b1, byte_in: 8'($urandom())};
   endfunction

   task automatic add_result(logic [7:0] b, kind_type k);
      decoded_q.push_back(rsp_payload_type'{out_byte: b, kind: k, last_result: 1'b0});
   endtask

   task automatic clear_run();
      run_value = '0;
      run_digits = '0;
   endtask

   task automatic string_byte(logic [7:0] c, bit eoi);
      if (eoi) begin
         add_result(8'h00, KIND_ERR);
         phase = PH_IDLE;
      end else if (c == QUOTE_CHAR) begin
         add_result(8'h00, KIND_DONE);
         phase = PH_IDLE;
      end else if (c == BACKSLASH_CHAR) begin
         phase = PH_ESC;
      end else begin
         add_result(c, KIND_DATA);
      end
   endtask

   // Updates the parser state for one accepted beat and queues its results.
   task automatic decode_byte(req_payload_type it, output bit ignored);
      logic [7:0] c;
      bit         eoi;
      int         depth;
      int         d;
      c = it.byte_in;
      eoi = it.end_of_input;
      depth = decoded_q.size();
      ignored = 1'b0;
      case (phase)
         PH_STR: string_byte(c, eoi);
         PH_ESC: begin
            phase = PH_STR;
            if (eoi) begin
               add_result(8'h00, KIND_ERR);
               phase = PH_IDLE;
            end else begin
               case (c)
                  8'h6E: add_result(8'h0A, KIND_DATA);
                  8'h74: add_result(8'h09, KIND_DATA);
                  8'h66: add_result(8'h0C, KIND_DATA);
                  8'h72: add_result(8'h0D, KIND_DATA);
                  8'h76: add_result(8'h0B, KIND_DATA);
                  8'h78: begin
                     clear_run();
                     phase = PH_HEX;
                  end
                  8'h30: begin
                     clear_run();
                     phase = PH_OCT;
                  end
                  default: begin
                     if (is_punct(c)) begin
                        add_result(c, KIND_DATA);
                     end else begin
                        add_result(8'h00, KIND_ERR);
                        phase = PH_IDLE;
                     end
                  end
               endcase
            end
         end
         PH_HEX: begin
            d = eoi ? -1 : hex_nibble(c);
            if (d >= 0) begin
               run_value = {run_value[4:0], 4'(d)};
               run_digits = run_digits + 2'd1;
               if (run_digits >= HEX_DIGITS_MAX) begin
                  add_result(run_value[7:0], KIND_DATA);
                  clear_run();
                  phase = PH_STR;
               end
            end else if (run_digits == 2'd0) begin
               add_result(8'h00, KIND_ERR);
               clear_run();
               phase = PH_IDLE;
            end else begin
               // run ended by a non-digit: emit value, then handle that byte in the string
               add_result(run_value[7:0], KIND_DATA);
               clear_run();
               phase = PH_STR;
               string_byte(c, eoi);
            end
         end
         PH_OCT: begin
            if (!eoi && c >= 8'h30 && c <= 8'h37) begin
               run_value = {run_value[5:0], c[2:0]};
               run_digits = run_digits + 2'd1;
               if (run_digits >= OCT_DIGITS_MAX) begin
                  if (run_value > BYTE_MAX_VALUE) begin
                     add_result(8'h00, KIND_ERR);
                     phase = PH_IDLE;
                  end else begin
                     add_result(run_value[7:0], KIND_DATA);
                     phase = PH_STR;
                  end
                  clear_run();
               end
            end else begin
               add_result(run_value[7:0], KIND_DATA);
               clear_run();
               phase = PH_STR;
               string_byte(c, eoi);
            end
         end
         default: begin
            phase = PH_IDLE;
            if (eoi) begin
               add_result(8'h00, KIND_FAIL);
            end else if (c == QUOTE_CHAR) begin
               clear_run();
               phase = PH_STR;
            end else if (!(skip_space && is_ws(c))) begin
               add_result(8'h00, KIND_FAIL);
            end else begin
               ignored = 1'b1;
            end
         end
      endcase
      if (decoded_q.size() > depth) decoded_q[$].last_result = 1'b1;
   endtask

   // Valid stays high after acceptance; the next call changes payload or drops it.
   task automatic send_char(req_payload_type p);
      bit ignored;
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      decode_byte(p, ignored);
      if (!ignored) items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_skip_space(bit v);
      if (phase != PH_IDLE) send_char(end_mark());
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      skip_space = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            note_failure($sformatf("unexpected beat: byte %02h kind %0d last %0b",
                                   rsp_payload.out_byte, rsp_payload.kind,
                                   rsp_payload.last_result));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_payload.out_byte !== want.out_byte || rsp_payload.kind !== want.kind ||
                rsp_payload.last_result !== want.last_result)
               note_failure($sformatf(
                  "mismatch: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
                  want.out_byte, want.kind, want.last_result, rsp_payload.out_byte,
                  rsp_payload.kind, rsp_payload.last_result));
         end
      end
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   task automatic test_directed();
      send_char(plain(8'h20));                    // skipped while idle
      send_char(plain(8'hFF));                    // not a string
      send_char(req_payload_type'{end_of_input: 1'b1, byte_in: 8'hFF});
      // one-digit hex ended by the closing quote: two results from one beat
      send_char(plain(QUOTE_CHAR));
      send_char(plain(BACKSLASH_CHAR));
      send_char(plain("x"));
      send_char(plain("4"));
      send_char(plain(QUOTE_CHAR));
      // octal at the top of the byte range, then one past it
      send_char(plain(QUOTE_CHAR));
      send_char(plain(BACKSLASH_CHAR));
      send_char(plain("0"));
      send_char(plain("3"));
      send_char(plain("7"));
      send_char(plain("7"));
      send_char(plain(BACKSLASH_CHAR));
      send_char(plain("0"));
      send_char(plain("4"));
      send_char(plain("0"));
      send_char(plain("0"));
      // hex escape with no digits
      send_char(plain(QUOTE_CHAR));
      send_char(plain(BACKSLASH_CHAR));
      send_char(plain("x"));
      send_char(plain("g"));
      // end of input inside the string and right after a backslash
      send_char(plain(QUOTE_CHAR));
      send_char(end_mark());
      send_char(plain(QUOTE_CHAR));
      send_char(plain(BACKSLASH_CHAR));
      send_char(end_mark());
   endtask

   task automatic test_space_not_skipped();
      write_skip_space(1'b0);
      send_char(plain(8'h20));
      send_char(plain(8'h09));
      send_char(plain(8'h0D));
      write_skip_space(1'b1);
   endtask

   task automatic send_random_string();
      logic [7:0] c;
      repeat ($urandom_range(0, 2)) begin
         c = ($urandom_range(0, 5) == 5) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4));
         send_char(plain(c));
      end
      send_char(plain(QUOTE_CHAR));
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 5))
            0, 1: begin
               c = 8'($urandom());
               if (c == QUOTE_CHAR || c == BACKSLASH_CHAR) c = 8'h41;
               send_char(plain(c));
            end
            2: begin
               send_char(plain(BACKSLASH_CHAR));
               case ($urandom_range(0, 4))
                  0: c = "n";
                  1: c = "t";
                  2: c = "f";
                  3: c = "r";
                  default: c = "v";
               endcase
               send_char(plain(c));
            end
            3: begin
               send_char(plain(BACKSLASH_CHAR));
               do c = 8'($urandom_range(8'h21, 8'h7E)); while (!is_punct(c));
               send_char(plain(c));
            end
            4: begin
               send_char(plain(BACKSLASH_CHAR));
               send_char(plain("x"));
               repeat ($urandom_range(1, 2)) begin
                  c = 8'($urandom_range(0, 15));
                  if (c < 10) c = c + 8'h30;
                  else c = c - 8'd10 + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
                  send_char(plain(c));
               end
            end
            default: begin
               send_char(plain(BACKSLASH_CHAR));
               send_char(plain("0"));
               repeat ($urandom_range(0, 3)) send_char(plain(8'(8'h30 + $urandom_range(0, 7))));
            end
         endcase
      end
      case ($urandom_range(0, 9))
         0: send_char(end_mark());
         1: begin
            send_char(plain(BACKSLASH_CHAR));
            c = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF))
                                     : 8'($urandom_range(8'h00, 8'h20));
            send_char(plain(c));
         end
         2: begin
            send_char(plain(BACKSLASH_CHAR));
            send_char(plain("x"));
            send_char(plain("z"));
         end
         default: send_char(plain(QUOTE_CHAR));
      endcase
   endtask

   task automatic test_random(int gap_pct, int stall_pct, bit skip);
      int target;
      write_skip_space(skip);
      send_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
      target = items_sent + RANDOM_ITEMS_PER_MODE;
      while (items_sent < target) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 4))
               send_char(($urandom_range(0, 7) == 0) ? end_mark() : plain(8'($urandom())));
         end else begin
            send_random_string();
         end
      end
   endtask

   task automatic test_backpressure();
      drain_results();
      send_gap_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 200;
      send_char(plain(QUOTE_CHAR));
      repeat (20) send_char(plain(8'($urandom_range(8'h61, 8'h7A))));
      send_char(plain(QUOTE_CHAR));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_space_not_skipped();
      test_random(0, 0, 1'b0);
      test_random(60, 0, 1'b1);
      test_random(0, 60, 1'b0);
      test_random(33, 33, 1'b1);
      test_backpressure();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/qsu_pkg.sv
design/quoted_string_unescape_parser.sv
design/qsu_checker.sv
tb/quoted_string_unescape_parser_test.sv
